// ===== rtl/dcps_pkg.sv =====
// Shared constants, register indexes and the controller state type for the capture phase scheduler.
package dcps_pkg;

  localparam int TIME_WIDTH_DEF  = 64;
  localparam int COUNT_WIDTH_DEF = 8;

  localparam int PER_W     = 40;
  localparam int NSEC_W    = 30;
  localparam int CFG_IW    = 3;
  localparam int CFG_DW    = 32;
  localparam int IN_TW     = 63;
  localparam int PHASE_W   = 32;
  localparam int SAMPLE_W  = 8;
  localparam int MARGIN_W  = 30;

  localparam logic [NSEC_W-1:0] ONE_SEC_NS = 30'd1000000000;

  localparam logic [CFG_DW-1:0]   RST_INIT_PERIOD = 32'd16680567;
  localparam logic [MARGIN_W-1:0] RST_MIN_DELAY   = 30'd2000000;
  localparam logic [MARGIN_W-1:0] RST_MARGIN      = 30'd2000000;
  localparam logic [SAMPLE_W-1:0] RST_SAMPLES     = 8'd10;
  localparam logic                RST_PPS         = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_INIT_PERIOD = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_DELAY   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MARGIN      = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SAMPLES     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_PPS         = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAS,
    ST_MUL,
    ST_MADD,
    ST_AVG_DIV,
    ST_CAP,
    ST_PH,
    ST_PH_DIV,
    ST_PLAN,
    ST_SUB,
    ST_FLOOR,
    ST_SEL,
    ST_OUT,
    ST_OUT_DIV,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/dcps_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle, quotient and remainder held.
module dcps_div #(
  parameter int DDW = 64,
  parameter int DVW = 40
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [DDW-1:0] dividend_i,
  input  logic [DVW-1:0] divisor_i,
  output logic           done_o,
  output logic [DDW-1:0] quo_o,
  output logic [DVW-1:0] rem_o
);

  localparam int CNW = $clog2(DDW + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [DDW-1:0] quo_q, quo_d;
  logic [DVW-1:0] rem_q, rem_d;
  logic [DVW-1:0] dvs_q, dvs_d;
  logic [DVW:0]   trial;
  logic [DVW:0]   diff;
  logic           fits;

  always_comb begin
    trial  = {rem_q, quo_q[DDW-1]};
    diff   = trial - {1'b0, dvs_q};
    fits   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNW'(DDW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[DVW-1:0] : trial[DVW-1:0];
      quo_d = {quo_q[DDW-2:0], fits};
      cnt_d = cnt_q - CNW'(1);
      if (cnt_q == CNW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/display_capture_phase_scheduler.sv =====
// Display capture phase scheduler: period averaging, capture planning and vsync phase output.
// One display event is taken when the block is idle and yields one result; the next event
// can be taken in the cycle after the result is loaded. The event is worked by the
// bit-serial divider, which runs up to three times per event (period average, pipeline
// phase modulo one second, output phase), and by the bit-serial multiplier of the
// average; a result waits in the output register while the next event is taken. Times
// saturate at the largest TIME_WIDTH-bit value.
module display_capture_phase_scheduler #(
  parameter int TIME_WIDTH  = dcps_pkg::TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = dcps_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dcps_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [dcps_pkg::CFG_DW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [dcps_pkg::IN_TW-1:0]    now_ns_i,
  input  logic [dcps_pkg::IN_TW-1:0]    render_start_ns_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dcps_pkg::PHASE_W-1:0]  vsync_delay_ns_o,
  output logic [dcps_pkg::IN_TW-1:0]    capture_at_ns_o,
  output logic [dcps_pkg::PHASE_W-1:0]  period_now_ns_o,
  output logic                          slow_camera_o,
  output logic                          period_settled_o
);

  localparam int TW   = TIME_WIDTH;
  localparam int CW   = COUNT_WIDTH;
  localparam int PEW  = dcps_pkg::PER_W;
  localparam int NSW  = dcps_pkg::NSEC_W;
  localparam int MW   = dcps_pkg::MARGIN_W;
  localparam int SMW  = dcps_pkg::SAMPLE_W;
  localparam int PHW  = dcps_pkg::PHASE_W;
  localparam int OTW  = dcps_pkg::IN_TW;
  localparam int AW   = PEW + CW + 1;
  localparam int DDW  = (TW > AW) ? TW : AW;
  localparam int CMPW = (CW > SMW) ? CW : SMW;
  localparam int SW   = $clog2(CW + 1);
  localparam logic [CW-1:0]  CMAX   = '1;
  localparam logic [PEW-1:0] P40MAX = '1;

  function automatic logic [TW-1:0] tadd(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? '1 : s[TW-1:0];
  endfunction

  dcps_pkg::state_e state_q, state_d;

  logic [TW-1:0]  prev_q, prev_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [PEW-1:0] est_q, est_d;
  logic [TW-1:0]  next_cap_q, next_cap_d;
  logic [TW-1:0]  last_rend_q, last_rend_d;
  logic [TW-1:0]  cached_q, cached_d;
  logic [MW-1:0]  mind_q, mind_d;
  logic [MW-1:0]  marg_q, marg_d;
  logic [SMW-1:0] smp_q, smp_d;
  logic           pps_q, pps_d;
  logic           out_valid_q, out_valid_d;
  logic [SW-1:0]  stp_q, stp_d;

  logic [TW-1:0]  now_q, now_d;
  logic [TW-1:0]  rend_q, rend_d;
  logic [PEW-1:0] meas_q, meas_d;
  logic [AW-1:0]  acc_q, acc_d;
  logic [CW-1:0]  mcnt_q, mcnt_d;
  logic [NSW-1:0] ph_q, ph_d;
  logic [TW-1:0]  plan_q, plan_d;
  logic [TW-1:0]  cap_q, cap_d;
  logic           slow_q, slow_d;
  logic [PHW-1:0] vsync_q, vsync_d;
  logic [OTW-1:0] capo_q, capo_d;
  logic [PHW-1:0] per_q, per_d;
  logic           slowo_q, slowo_d;
  logic           setl_q, setl_d;

  logic [TW:0]    gap;
  logic [PEW-1:0] meas_w;
  logic [CW-1:0]  cnt_inc;

  logic           div_start;
  logic [DDW-1:0] div_dvd;
  logic [PEW-1:0] div_dvs;
  logic           div_done;
  logic [DDW-1:0] div_quo;
  logic [PEW-1:0] div_rem;

  dcps_div #(
    .DDW (DDW),
    .DVW (PEW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    gap     = {1'b0, now_q} - {1'b0, prev_q};
    if (gap[TW]) begin
      meas_w = '0;
    end else if (gap[TW-1:0] > TW'(P40MAX)) begin
      meas_w = P40MAX;
    end else begin
      meas_w = PEW'(gap[TW-1:0]);
    end
    cnt_inc = (cnt_q == CMAX) ? cnt_q : cnt_q + CW'(1);

    state_d     = state_q;
    prev_d      = prev_q;
    cnt_d       = cnt_q;
    est_d       = est_q;
    next_cap_d  = next_cap_q;
    last_rend_d = last_rend_q;
    cached_d    = cached_q;
    mind_d      = mind_q;
    marg_d      = marg_q;
    smp_d       = smp_q;
    pps_d       = pps_q;
    out_valid_d = out_valid_q;
    stp_d       = stp_q;
    now_d       = now_q;
    rend_d      = rend_q;
    meas_d      = meas_q;
    acc_d       = acc_q;
    mcnt_d      = mcnt_q;
    ph_d        = ph_q;
    plan_d      = plan_q;
    cap_d       = cap_q;
    slow_d      = slow_q;
    vsync_d     = vsync_q;
    capo_d      = capo_q;
    per_d       = per_q;
    slowo_d     = slowo_q;
    setl_d      = setl_q;
    div_start   = 1'b0;
    div_dvd     = '0;
    div_dvs     = '0;
    in_stall_o  = (state_q != dcps_pkg::ST_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      case (cfg_idx_i)
        dcps_pkg::CFG_INIT_PERIOD: begin
          if (cnt_q == '0) begin
            est_d = PEW'(cfg_data_i);
          end
        end
        dcps_pkg::CFG_MIN_DELAY: mind_d = cfg_data_i[MW-1:0];
        dcps_pkg::CFG_MARGIN:    marg_d = cfg_data_i[MW-1:0];
        dcps_pkg::CFG_SAMPLES:   smp_d  = cfg_data_i[SMW-1:0];
        dcps_pkg::CFG_PPS:       pps_d  = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      dcps_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          now_d   = TW'(now_ns_i);
          rend_d  = TW'(render_start_ns_i);
          state_d = dcps_pkg::ST_MEAS;
        end
      end
      dcps_pkg::ST_MEAS: begin
        prev_d  = now_q;
        state_d = dcps_pkg::ST_CAP;
        if (prev_q != '0 && CMPW'(cnt_q) < CMPW'(smp_q)) begin
          meas_d = meas_w;
          if (cnt_q == '0) begin
            est_d = meas_w;
            cnt_d = cnt_inc;
          end else begin
            acc_d   = '0;
            mcnt_d  = cnt_q;
            stp_d   = '0;
            state_d = dcps_pkg::ST_MUL;
          end
        end
      end
      dcps_pkg::ST_MUL: begin
        acc_d  = {acc_q[AW-2:0], 1'b0} + (mcnt_q[CW-1] ? AW'(est_q) : '0);
        mcnt_d = {mcnt_q[CW-2:0], 1'b0};
        stp_d  = stp_q + SW'(1);
        if (stp_q == SW'(CW - 1)) begin
          state_d = dcps_pkg::ST_MADD;
        end
      end
      dcps_pkg::ST_MADD: begin
        div_start = 1'b1;
        div_dvd   = DDW'(acc_q + AW'(meas_q));
        div_dvs   = PEW'(cnt_q) + PEW'(1);
        state_d   = dcps_pkg::ST_AVG_DIV;
      end
      dcps_pkg::ST_AVG_DIV: begin
        if (div_done) begin
          est_d   = div_quo[PEW-1:0];
          cnt_d   = cnt_inc;
          state_d = dcps_pkg::ST_CAP;
        end
      end
      dcps_pkg::ST_CAP: begin
        if (rend_q == '0 || next_cap_q == '0) begin
          cap_d   = tadd(now_q, TW'(mind_q));
          slow_d  = 1'b0;
          state_d = dcps_pkg::ST_OUT;
        end else begin
          slow_d      = (rend_q == last_rend_q);
          last_rend_d = rend_q;
          if (rend_q >= next_cap_q) begin
            cached_d = rend_q - next_cap_q;
          end
          state_d = dcps_pkg::ST_PH;
        end
      end
      dcps_pkg::ST_PH: begin
        div_start = 1'b1;
        div_dvd   = DDW'(tadd(cached_q, TW'(marg_q)));
        div_dvs   = PEW'(dcps_pkg::ONE_SEC_NS);
        state_d   = dcps_pkg::ST_PH_DIV;
      end
      dcps_pkg::ST_PH_DIV: begin
        if (div_done) begin
          ph_d    = div_rem[NSW-1:0];
          state_d = dcps_pkg::ST_PLAN;
        end
      end
      dcps_pkg::ST_PLAN: begin
        plan_d  = tadd(now_q, TW'(est_q));
        state_d = dcps_pkg::ST_SUB;
      end
      dcps_pkg::ST_SUB: begin
        plan_d  = (plan_q >= TW'(ph_q)) ? plan_q - TW'(ph_q) : '0;
        state_d = dcps_pkg::ST_FLOOR;
      end
      dcps_pkg::ST_FLOOR: begin
        cap_d   = tadd(now_q, TW'(mind_q));
        state_d = dcps_pkg::ST_SEL;
      end
      dcps_pkg::ST_SEL: begin
        if (plan_q > cap_q) begin
          cap_d = plan_q;
        end
        state_d = dcps_pkg::ST_OUT;
      end
      dcps_pkg::ST_OUT: begin
        next_cap_d = cap_q;
        div_start  = 1'b1;
        div_dvd    = DDW'(cap_q);
        div_dvs    = (pps_q || est_q == '0) ? PEW'(dcps_pkg::ONE_SEC_NS) : est_q;
        state_d    = dcps_pkg::ST_OUT_DIV;
      end
      dcps_pkg::ST_OUT_DIV: begin
        if (div_done) begin
          state_d = dcps_pkg::ST_EMIT;
        end
      end
      dcps_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          vsync_d     = div_rem[PHW-1:0];
          capo_d      = OTW'(cap_q);
          per_d       = (est_q > PEW'({PHW{1'b1}})) ? '1 : est_q[PHW-1:0];
          slowo_d     = slow_q;
          setl_d      = (CMPW'(cnt_q) >= CMPW'(smp_q));
          state_d     = dcps_pkg::ST_IDLE;
        end
      end
      default: state_d = dcps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dcps_pkg::ST_IDLE;
      prev_q      <= '0;
      cnt_q       <= '0;
      est_q       <= PEW'(dcps_pkg::RST_INIT_PERIOD);
      next_cap_q  <= '0;
      last_rend_q <= '0;
      cached_q    <= '0;
      mind_q      <= dcps_pkg::RST_MIN_DELAY;
      marg_q      <= dcps_pkg::RST_MARGIN;
      smp_q       <= dcps_pkg::RST_SAMPLES;
      pps_q       <= dcps_pkg::RST_PPS;
      out_valid_q <= 1'b0;
      stp_q       <= '0;
    end else begin
      state_q     <= state_d;
      prev_q      <= prev_d;
      cnt_q       <= cnt_d;
      est_q       <= est_d;
      next_cap_q  <= next_cap_d;
      last_rend_q <= last_rend_d;
      cached_q    <= cached_d;
      mind_q      <= mind_d;
      marg_q      <= marg_d;
      smp_q       <= smp_d;
      pps_q       <= pps_d;
      out_valid_q <= out_valid_d;
      stp_q       <= stp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    rend_q  <= rend_d;
    meas_q  <= meas_d;
    acc_q   <= acc_d;
    mcnt_q  <= mcnt_d;
    ph_q    <= ph_d;
    plan_q  <= plan_d;
    cap_q   <= cap_d;
    slow_q  <= slow_d;
    vsync_q <= vsync_d;
    capo_q  <= capo_d;
    per_q   <= per_d;
    slowo_q <= slowo_d;
    setl_q  <= setl_d;
  end

  assign out_valid_o      = out_valid_q;
  assign vsync_delay_ns_o = vsync_q;
  assign capture_at_ns_o  = capo_q;
  assign period_now_ns_o  = per_q;
  assign slow_camera_o    = slowo_q;
  assign period_settled_o = setl_q;

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == dcps_pkg::ST_EMIT))
    else $error("result raised outside emit state");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == dcps_pkg::ST_AVG_DIV || state_q == dcps_pkg::ST_PH_DIV ||
                  state_q == dcps_pkg::ST_OUT_DIV))
    else $error("divider finished while controller not waiting");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("sample count moved by other than one");

  a_ph_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dcps_pkg::ST_SUB) |-> (ph_q < dcps_pkg::ONE_SEC_NS))
    else $error("pipeline phase not below one second");

endmodule
